// File: rtl/cmsk_pkg.sv
// Shared constants, controller/datapath interface types and the mixing function.
package cmsk_pkg;

	localparam int WIDTH_MAX_DEF    = 1024;
	localparam int DEPTH_MAX_DEF    = 8;
	localparam int COUNTER_BITS_DEF = 32;

	localparam logic [63:0] GOLDEN     = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIXA       = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIXB       = 64'h94d049bb133111eb;
	localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;

	localparam int SHIFT_A = 30;
	localparam int SHIFT_B = 27;
	localparam int SHIFT_C = 31;

	localparam logic [1:0] CFG_WIDTH = 2'd0;
	localparam logic [1:0] CFG_DEPTH = 2'd1;
	localparam logic [1:0] CFG_SEED  = 2'd2;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic clr_step;
		logic take_item;
		logic row_clr;
		logic row_inc;
		logic mix_seed;
		logic mix_fin;
		logic seed_wr;
		logic byte_upd;
		logic div_start;
		logic upd;
		logic min_init;
		logic out_load;
	} cmsk_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mix_done;
		logic div_done;
		logic seed_last;
		logic fin_last;
		logic has_byte;
		logic last;
		logic is_query;
		logic out_free;
	} cmsk_stat_t;

	// Evaluated only at elaboration to build the per-row seed constants.
	function automatic logic [63:0] mix64(input logic [63:0] v);
		logic [63:0] t;
		t = v + GOLDEN;
		t = (t ^ (t >> SHIFT_A)) * MIXA;
		t = (t ^ (t >> SHIFT_B)) * MIXB;
		return t ^ (t >> SHIFT_C);
	endfunction

endpackage

// File: rtl/cmsk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmsk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/cmsk_mix.sv
// Iterative splitmix64 finalizer built on one shared 32x32 multiplier.
module cmsk_mix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] din,
	output logic        done,
	output logic [63:0] dout
);
	import cmsk_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [2:0]  phase_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] dout_q;
	logic [63:0] v;
	logic [63:0] k;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic [63:0] term;
	logic [63:0] acc_n;

	// Each 64-bit product keeps only its low half: lo*lo plus both cross terms.
	always_comb begin
		v = din + GOLDEN;
		k = (phase_q < 3'd3) ? MIXA : MIXB;
		op_a = x_q[31:0];
		op_b = k[31:0];
		case (phase_q) inside
			3'd1, 3'd4: op_b = k[63:32];
			3'd2, 3'd5: op_a = x_q[63:32];
			default: ;
		endcase
		prod = op_a * op_b;
		case (phase_q) inside
			3'd0, 3'd3: term = prod;
			default: term = {prod[31:0], 32'd0};
		endcase
		acc_n = acc_q + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 3'd0;
			end else if (busy_q) begin
				phase_q <= phase_q + 3'd1;
				if (phase_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= v ^ (v >> SHIFT_A);
			acc_q <= 64'd0;
		end else if (busy_q) begin
			acc_q <= acc_n;
			if (phase_q == 3'd2) begin
				x_q   <= acc_n ^ (acc_n >> SHIFT_B);
				acc_q <= 64'd0;
			end
			if (phase_q == 3'd5) begin
				dout_q <= acc_n ^ (acc_n >> SHIFT_C);
			end
		end
	end

	assign done = done_q;
	assign dout = dout_q;

endmodule

// File: rtl/cmsk_ctrl.sv
// Controller state machine sequencing clearing, seeding, byte updates and key finalization.
module cmsk_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cmsk_pkg::cmsk_stat_t stat,
	output cmsk_pkg::cmsk_cmd_t  cmd
);
	import cmsk_pkg::*;

	typedef enum logic [10:0] {
		S_CLEAR = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_SEED  = 11'b00000000100,
		S_SEEDW = 11'b00000001000,
		S_BYTE  = 11'b00000010000,
		S_FIN   = 11'b00000100000,
		S_FINW  = 11'b00001000000,
		S_DIVW  = 11'b00010000000,
		S_RD    = 11'b00100000000,
		S_UPD   = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   in_key_q;
	logic   in_key_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n  = state_q;
		in_key_n = in_key_q;
		cmd      = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					if (in_key_q) begin
						state_n = S_BYTE;
					end else begin
						cmd.row_clr = 1'b1;
						state_n     = S_SEED;
					end
				end
			end
			S_SEED: begin
				cmd.mix_seed = 1'b1;
				state_n      = S_SEEDW;
			end
			S_SEEDW: begin
				if (stat.mix_done) begin
					cmd.seed_wr = 1'b1;
					if (stat.seed_last) begin
						state_n = S_BYTE;
					end else begin
						cmd.row_inc = 1'b1;
						state_n     = S_SEED;
					end
				end
			end
			S_BYTE: begin
				cmd.byte_upd = stat.has_byte;
				in_key_n     = 1'b1;
				if (stat.last) begin
					in_key_n     = 1'b0;
					cmd.row_clr  = 1'b1;
					cmd.min_init = 1'b1;
					state_n      = S_FIN;
				end else begin
					state_n = S_IDLE;
				end
			end
			S_FIN: begin
				cmd.mix_fin = 1'b1;
				state_n     = S_FINW;
			end
			S_FINW: begin
				if (stat.mix_done) begin
					cmd.div_start = 1'b1;
					state_n       = S_DIVW;
				end
			end
			S_DIVW: begin
				if (stat.div_done) begin
					state_n = S_RD;
				end
			end
			S_RD: begin
				// The counter read issued here returns in the next cycle.
				state_n = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				if (stat.fin_last) begin
					state_n = stat.is_query ? S_OUT : S_IDLE;
				end else begin
					cmd.row_inc = 1'b1;
					state_n     = S_FIN;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			in_key_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			in_key_q <= in_key_n;
		end
	end

endmodule

// File: rtl/cmsk_dp.sv
// Datapath: configuration, row hash states, mixer, column divider, counter memory, result.
module cmsk_dp #(
	parameter int WIDTH_MAX    = cmsk_pkg::WIDTH_MAX_DEF,
	parameter int DEPTH_MAX    = cmsk_pkg::DEPTH_MAX_DEF,
	parameter int COUNTER_BITS = cmsk_pkg::COUNTER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmsk_pkg::cmsk_cmd_t  cmd,
	output cmsk_pkg::cmsk_stat_t stat,
	input  logic                 in_command,
	input  logic [7:0]           in_key_byte,
	input  logic                 in_has_byte,
	input  logic                 in_last,
	input  logic [31:0]          in_add_count,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          out_estimate,
	output logic                 out_saturated
);
	import cmsk_pkg::*;

	localparam int ENTRIES   = DEPTH_MAX * WIDTH_MAX;
	localparam int AB        = $clog2(ENTRIES);
	localparam int COLB      = $clog2(WIDTH_MAX);
	localparam int WB        = $clog2(WIDTH_MAX + 1);
	localparam int DB        = $clog2(DEPTH_MAX + 1);
	localparam int RB        = $clog2(DEPTH_MAX);
	localparam int SW        = ((COUNTER_BITS > 32) ? COUNTER_BITS : 32) + 1;
	localparam int WIDTH_RST = (WIDTH_MAX < 1024) ? WIDTH_MAX : 1024;
	localparam int DEPTH_RST = (DEPTH_MAX < 4) ? DEPTH_MAX : 4;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

	logic [WB-1:0]           width_q;
	logic [DB-1:0]           depth_q;
	logic [63:0]             seed_q;
	logic                    cmd_q;
	logic [7:0]              byte_q;
	logic                    has_q;
	logic                    last_q;
	logic [31:0]             count_q;
	logic [RB-1:0]           row_q;
	logic [AB-1:0]           clr_addr_q;
	logic [63:0]             row_hash_q [DEPTH_MAX];
	logic [63:0]             seed_k [DEPTH_MAX];
	logic                    div_busy_q;
	logic                    div_done_q;
	logic [5:0]              div_cnt_q;
	logic [63:0]             dividend_q;
	logic [COLB-1:0]         rem_q;
	logic [COUNTER_BITS-1:0] minv_q;
	logic                    out_valid_q;
	logic [31:0]             est_q;
	logic                    sat_q;
	logic [10:0]             w_in;
	logic [3:0]              d_in;
	logic                    mix_done;
	logic [63:0]             mix_out;
	logic [63:0]             mix_in;
	logic [COLB:0]           cand;
	logic [COLB:0]           cand_red;
	logic [AB-1:0]           fin_addr;
	logic [COUNTER_BITS-1:0] ram_rdata;
	logic [COUNTER_BITS-1:0] ram_wdata;
	logic                    ram_we;
	logic [31:0]             inc;
	logic [SW-1:0]           sum;
	logic [COUNTER_BITS-1:0] bumped;

	for (genvar g = 0; g < DEPTH_MAX; g++) begin : g_seed
		localparam logic [63:0] K = mix64(64'(g));
		assign seed_k[g] = K;
	end

	assign w_in = cfg_data[10:0];
	assign d_in = cfg_data[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WB'(WIDTH_RST);
			depth_q <= DB'(DEPTH_RST);
			seed_q  <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH: begin
					if (w_in < 11'd16) begin
						width_q <= WB'(16);
					end else if (32'(w_in) > 32'(WIDTH_MAX)) begin
						width_q <= WB'(WIDTH_MAX);
					end else begin
						width_q <= WB'(w_in);
					end
				end
				CFG_DEPTH: begin
					if (d_in < 4'd2) begin
						depth_q <= DB'(2);
					end else if (32'(d_in) > 32'(DEPTH_MAX)) begin
						depth_q <= DB'(DEPTH_MAX);
					end else begin
						depth_q <= DB'(d_in);
					end
				end
				CFG_SEED: seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			cmd_q   <= in_command;
			byte_q  <= in_key_byte;
			has_q   <= in_has_byte;
			last_q  <= in_last;
			count_q <= in_add_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.row_clr) begin
				row_q <= '0;
			end else if (cmd.row_inc) begin
				row_q <= row_q + RB'(1);
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + AB'(1);
			end
		end
	end

	// FNV-1a step: multiplying by the prime 2^40 + 0x1b3 is done by shifts and adds.
	for (genvar g = 0; g < DEPTH_MAX; g++) begin : g_row
		logic [63:0] x;
		assign x = row_hash_q[g] ^ {56'd0, byte_q};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				row_hash_q[g] <= 64'd0;
			end else if (cmd.seed_wr && row_q == RB'(g)) begin
				row_hash_q[g] <= FNV_OFFSET ^ mix_out;
			end else if (cmd.byte_upd) begin
				row_hash_q[g] <= (x << 40) + (x << 8) + (x << 7) + (x << 5)
				                 + (x << 4) + (x << 1) + x;
			end
		end
	end

	assign mix_in = cmd.mix_fin ? row_hash_q[row_q] : (seed_q ^ seed_k[row_q]);

	cmsk_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mix_seed | cmd.mix_fin),
		.din    (mix_in),
		.done   (mix_done),
		.dout   (mix_out)
	);

	// Restoring remainder, one dividend bit per cycle.
	assign cand     = {rem_q, dividend_q[63]};
	assign cand_red = (cand >= (COLB + 1)'(width_q)) ? cand - (COLB + 1)'(width_q) : cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_cnt_q  <= 6'd0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= 6'd0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 6'd1;
				if (div_cnt_q == 6'd63) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dividend_q <= mix_out;
			rem_q      <= '0;
		end else if (div_busy_q) begin
			dividend_q <= dividend_q << 1;
			rem_q      <= cand_red[COLB-1:0];
		end
	end

	assign fin_addr = AB'(AB'(row_q) * AB'(WIDTH_MAX) + AB'(rem_q));

	assign inc    = (count_q == 32'd0) ? 32'd1 : count_q;
	assign sum    = SW'(ram_rdata) + SW'(inc);
	assign bumped = (sum >= SW'(CNT_MAX)) ? CNT_MAX : sum[COUNTER_BITS-1:0];

	assign ram_we    = cmd.clr_step || (cmd.upd && cmd_q == CMD_ADD);
	assign ram_wdata = cmd.clr_step ? '0 : bumped;

	cmsk_ram #(
		.WIDTH (COUNTER_BITS),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.clr_step ? clr_addr_q : fin_addr),
		.wdata (ram_wdata),
		.raddr (fin_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.min_init) begin
			minv_q <= CNT_MAX;
		end else if (cmd.upd && cmd_q == CMD_QUERY && ram_rdata < minv_q) begin
			minv_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			est_q <= 32'(minv_q);
			sat_q <= (minv_q == CNT_MAX);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_estimate  = est_q;
	assign out_saturated = sat_q;

	assign stat.clr_last  = (clr_addr_q == AB'(ENTRIES - 1));
	assign stat.mix_done  = mix_done;
	assign stat.div_done  = div_done_q;
	assign stat.seed_last = (row_q == RB'(DEPTH_MAX - 1));
	assign stat.fin_last  = (DB'(row_q) + DB'(1) >= depth_q);
	assign stat.has_byte  = has_q;
	assign stat.last      = last_q;
	assign stat.is_query  = (cmd_q == CMD_QUERY);
	assign stat.out_free  = !out_valid_q || out_ready;

endmodule

// File: rtl/count_min_sketch_update_query_unit.sv
// Count-min sketch top level: stream key bytes in, query estimates out.
// The first item of a key also seeds every one of the DEPTH_MAX rows through the shared
// mixer. The last item runs each row in use through the mixer, the column divider and
// the counter read-modify-write; one item is in work at a time. After reset all
// DEPTH_MAX*WIDTH_MAX counters (8192 by default) are cleared before the first item is
// accepted; configuration writes are always taken.
module count_min_sketch_update_query_unit #(
	parameter int WIDTH_MAX    = cmsk_pkg::WIDTH_MAX_DEF,
	parameter int DEPTH_MAX    = cmsk_pkg::DEPTH_MAX_DEF,
	parameter int COUNTER_BITS = cmsk_pkg::COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // key_byte[7:0], add_count[39:8]
	input  logic        s_axis_tlast,
	input  logic [1:0]  s_axis_tuser,  // command[0], has_byte[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // estimate[31:0]
	output logic        m_axis_tuser,  // saturated[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import cmsk_pkg::*;

	cmsk_cmd_t  cmd;
	cmsk_stat_t stat;

	assign cfg_ready = 1'b1;

	cmsk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cmsk_dp #(
		.WIDTH_MAX    (WIDTH_MAX),
		.DEPTH_MAX    (DEPTH_MAX),
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_command    (s_axis_tuser[0]),
		.in_key_byte   (s_axis_tdata[7:0]),
		.in_has_byte   (s_axis_tuser[1]),
		.in_last       (s_axis_tlast),
		.in_add_count  (s_axis_tdata[39:8]),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_estimate  (m_axis_tdata),
		.out_saturated (m_axis_tuser)
	);

endmodule
